@@ rtl/hop_frame_deframer_macros.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef HOP_FRAME_DEFRAMER_MACROS_SVH
`define HOP_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HFD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HFD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ rtl/hfd_pkg.sv @@
// Types, constants and the CRC function of the frame deframer.
package hfd_pkg;

  localparam int HEADER_BYTES = 32;
  localparam int CRC_BYTES    = 4;
  localparam logic [7:0]  MAGIC0      = 8'h45;
  localparam logic [7:0]  MAGIC1      = 8'h4C;
  localparam logic [7:0]  MAJOR_RESET = 8'd2;
  localparam logic [15:0] HEADER_LEN  = 16'd32;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [3:0]  NO_FIELD    = 4'd15;

  // Header byte positions that carry a check or a stored field.
  localparam logic [4:0] POS_MAGIC0    = 5'd0;
  localparam logic [4:0] POS_MAGIC1    = 5'd1;
  localparam logic [4:0] POS_MAJOR     = 5'd2;
  localparam logic [4:0] POS_HDR_LEN   = 5'd11;
  localparam logic [4:0] POS_FRAG_IDX  = 5'd25;
  localparam logic [4:0] POS_FRAG_CNT  = 5'd27;
  localparam logic [4:0] POS_PAY_LEN   = 5'd29;
  localparam logic [4:0] POS_RESERVED  = 5'd31;

  // Byte lane of each header position inside its field.
  localparam logic [1:0] LANE_TAB [32] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1};

  // Reported field id for the position that completes a field.
  localparam logic [3:0] CODE_TAB [32] = '{
    4'd15, 4'd15, 4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,
    4'd15, 4'd6,  4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd7,
    4'd15, 4'd15, 4'd15, 4'd8,  4'd15, 4'd15, 4'd15, 4'd9,
    4'd15, 4'd10, 4'd15, 4'd11, 4'd15, 4'd12, 4'd15, 4'd15};

  typedef enum logic [1:0] {
    KIND_FIELD   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_MAJOR     = 3'd3,
    ST_HDR_LEN   = 3'd4,
    ST_RESERVED  = 3'd5,
    ST_FRAGMENT  = 3'd6,
    ST_CRC       = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CRC_NONE     = 2'd0,
    CRC_MATCH    = 2'd1,
    CRC_MISMATCH = 2'd2
  } crc_check_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [3:0]  field_code;
    logic [31:0] field_value;
    logic [7:0]  payload_byte;
    status_t     status;
    logic        frame_ok;
    logic        out_last;
  } out_t;

  // Reflected CRC-32 advanced by one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/hop_frame_deframer.sv @@
// Top level of the streaming length-prefixed frame deframer with CRC-32 check.
//
// The deframer takes one frame word (a byte plus a last flag) per clock and can accept a
// word in every cycle while the result queue has room. The 32-byte little-endian header
// is parsed on the fly: each completed header field comes out as a field result, payload
// bytes come out as payload results as they arrive, and the word flagged last produces a
// final status result with frame_ok. A reflected CRC-32 over header and payload is compared
// with the four bytes that follow the payload. All parsing is done in the cycle a word is
// accepted, and its results go into a four-entry result queue that parts the two sides;
// the input stalls only while fewer than two queue entries are free. The queue emits one
// result per cycle while result_stall is low; a last word that also carries a field or a
// payload byte yields two results. The configuration register expected_major (reset 2)
// may be written with cfg_write while the block is idle.
module hop_frame_deframer
  import hfd_pkg::*;
#(
  parameter int COUNT_BITS = 17
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  in_t        byte_data,
  output logic       result_valid,
  input  logic       result_stall,
  output out_t       result_data
);

`include "hop_frame_deframer_macros.svh"

  // Width of the frame length, which may reach one past the saturated count.
  localparam int LW = (COUNT_BITS < 32) ? COUNT_BITS + 1 : 32;
  // Common width for comparing positions with the payload end.
  localparam int MW = (LW > 18) ? LW : 18;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam int QDEPTH = 4;

  // Frame state.
  logic [7:0]            expected_major;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [31:0]           field_shift, field_shift_next;
  logic [15:0]           payload_length_reg, payload_length_reg_next;
  logic [15:0]           fragment_index_reg, fragment_index_reg_next;
  logic [15:0]           fragment_count_reg, fragment_count_reg_next;
  logic [15:0]           header_length_reg, header_length_reg_next;
  status_t               first_error, first_error_next;
  logic [31:0]           crc_running, crc_running_next;
  logic [31:0]           received_crc, received_crc_next;
  crc_check_t            crc_checked, crc_checked_next;

  // Result queue.
  out_t       queue [QDEPTH];
  logic [1:0] head, tail;
  logic [2:0] count;

  logic       byte_acc, pop;
  logic       has_first;
  out_t       first_res, status_res;

  assign byte_stall   = (count > 3'd2);
  assign byte_acc     = byte_valid && !byte_stall;
  assign result_valid = (count != 3'd0);
  assign result_data  = queue[head];
  assign pop          = result_valid && !result_stall;

  always_comb begin
    logic [7:0]    b;
    logic [1:0]    lane;
    logic [4:0]    hpos;
    logic [31:0]   acc;
    logic [MW-1:0] pos_m, end_old, end_new;
    logic [MW-1:0] len_m;
    logic [LW-1:0] len;
    logic [MW-1:0] k_full;
    logic [1:0]    k;
    status_t       st;

    b    = byte_data.in_byte;
    hpos = byte_count[4:0];
    lane = LANE_TAB[hpos];
    acc  = ((lane != 2'd0) ? field_shift : 32'd0) | ({24'd0, b} << {lane, 3'b000});
    pos_m   = MW'(byte_count);
    end_old = MW'(HEADER_BYTES) + MW'(payload_length_reg);
    k_full  = pos_m - end_old;
    k       = k_full[1:0];

    byte_count_next         = (byte_count < COUNT_MAX) ? byte_count + 1'b1 : byte_count;
    field_shift_next        = field_shift;
    payload_length_reg_next = payload_length_reg;
    fragment_index_reg_next = fragment_index_reg;
    fragment_count_reg_next = fragment_count_reg;
    header_length_reg_next  = header_length_reg;
    first_error_next        = first_error;
    crc_running_next        = crc_running;
    received_crc_next       = received_crc;
    crc_checked_next        = crc_checked;

    has_first = 1'b0;
    first_res = '0;

    if (pos_m < MW'(HEADER_BYTES)) begin
      field_shift_next = acc;
      crc_running_next = crc_byte(crc_running, b);
      if (hpos == POS_MAGIC0 && b != MAGIC0 && first_error_next == ST_OK) begin
        first_error_next = ST_MAGIC;
      end
      if (hpos == POS_MAGIC1 && b != MAGIC1 && first_error_next == ST_OK) begin
        first_error_next = ST_MAGIC;
      end
      if (hpos == POS_MAJOR && b != expected_major && first_error_next == ST_OK) begin
        first_error_next = ST_MAJOR;
      end
      if (hpos == POS_HDR_LEN) begin
        header_length_reg_next = acc[15:0];
        if (acc[15:0] != HEADER_LEN && first_error_next == ST_OK) begin
          first_error_next = ST_HDR_LEN;
        end
      end
      if (hpos == POS_FRAG_IDX) begin
        fragment_index_reg_next = acc[15:0];
      end
      if (hpos == POS_FRAG_CNT) begin
        fragment_count_reg_next = acc[15:0];
      end
      if (hpos == POS_PAY_LEN) begin
        payload_length_reg_next = acc[15:0];
      end
      if (hpos == POS_RESERVED) begin
        if (acc[15:0] != 16'd0 && first_error_next == ST_OK) begin
          first_error_next = ST_RESERVED;
        end
        if ((fragment_count_reg == 16'd0 || fragment_index_reg >= fragment_count_reg) &&
            first_error_next == ST_OK) begin
          first_error_next = ST_FRAGMENT;
        end
      end
      if (CODE_TAB[hpos] != NO_FIELD) begin
        has_first             = 1'b1;
        first_res.result_kind = KIND_FIELD;
        first_res.field_code  = CODE_TAB[hpos];
        first_res.field_value = acc;
        first_res.status      = ST_OK;
      end
    end else if (pos_m < end_old) begin
      crc_running_next       = crc_byte(crc_running, b);
      has_first              = 1'b1;
      first_res.result_kind  = KIND_PAYLOAD;
      first_res.payload_byte = b;
      first_res.status       = ST_OK;
    end else if (pos_m < end_old + MW'(CRC_BYTES)) begin
      received_crc_next = received_crc | ({24'd0, b} << {k, 3'b000});
      if (k == 2'd3) begin
        crc_checked_next = (received_crc_next == ~crc_running) ? CRC_MATCH : CRC_MISMATCH;
      end
    end

    // Final status, from the state as this word leaves it.
    len     = LW'(byte_count) + 1'b1;
    len_m   = MW'(len);
    end_new = MW'(HEADER_BYTES) + MW'(payload_length_reg_next);
    if (len_m < MW'(HEADER_BYTES + CRC_BYTES)) begin
      st = ST_TOO_SHORT;
    end else if (first_error_next != ST_OK) begin
      st = first_error_next;
    end else if (len_m < end_new + MW'(CRC_BYTES)) begin
      st = ST_TOO_SHORT;
    end else if (crc_checked_next == CRC_MISMATCH) begin
      st = ST_CRC;
    end else begin
      st = ST_OK;
    end
    status_res             = '0;
    status_res.result_kind = KIND_STATUS;
    status_res.status      = st;
    status_res.frame_ok    = (st == ST_OK);
    status_res.out_last    = 1'b1;

    // The last word returns the whole frame state to its reset value.
    if (byte_data.in_last) begin
      byte_count_next         = '0;
      field_shift_next        = '0;
      payload_length_reg_next = '0;
      fragment_index_reg_next = '0;
      fragment_count_reg_next = '0;
      header_length_reg_next  = '0;
      first_error_next        = ST_OK;
      crc_running_next        = '1;
      received_crc_next       = '0;
      crc_checked_next        = CRC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_major <= MAJOR_RESET;
    end else if (cfg_write) begin
      expected_major <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count         <= '0;
      field_shift        <= '0;
      payload_length_reg <= '0;
      fragment_index_reg <= '0;
      fragment_count_reg <= '0;
      header_length_reg  <= '0;
      first_error        <= ST_OK;
      crc_running        <= '1;
      received_crc       <= '0;
      crc_checked        <= CRC_NONE;
    end else if (byte_acc) begin
      byte_count         <= byte_count_next;
      field_shift        <= field_shift_next;
      payload_length_reg <= payload_length_reg_next;
      fragment_index_reg <= fragment_index_reg_next;
      fragment_count_reg <= fragment_count_reg_next;
      header_length_reg  <= header_length_reg_next;
      first_error        <= first_error_next;
      crc_running        <= crc_running_next;
      received_crc       <= received_crc_next;
      crc_checked        <= crc_checked_next;
    end
  end

  // Queue writes: the field or payload result first, then the status behind it.
  always_ff @(posedge clk) begin
    if (byte_acc) begin
      if (has_first) begin
        queue[tail] <= first_res;
        if (byte_data.in_last) begin
          queue[tail + 2'd1] <= status_res;
        end
      end else if (byte_data.in_last) begin
        queue[tail] <= status_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [2:0] pushed;
    pushed = byte_acc ? (3'(has_first) + 3'(byte_data.in_last)) : 3'd0;
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + pushed[1:0];
      head  <= head + 2'(pop);
      count <= count + pushed - 3'(pop);
    end
  end

  `HFD_ASSERT_IMP(a_queue_bound, clk, rst, 1'b1, count <= 3'(QDEPTH))
  `HFD_ASSERT_NXT(a_frame_restart, clk, rst, byte_acc && byte_data.in_last,
                  byte_count == '0 && crc_running == '1 && first_error == ST_OK)
  `HFD_ASSERT_NXT(a_count_saturates, clk, rst,
                  byte_acc && !byte_data.in_last && byte_count == COUNT_MAX,
                  byte_count == COUNT_MAX)
  `HFD_ASSERT_IMP(a_status_marks_end, clk, rst, result_valid,
                  (result_data.result_kind == KIND_STATUS) == result_data.out_last)

endmodule
